// File: rtl/core/cbbd_pkg.sv
// Shared types, constants and register map of the cassette bit block deframer.
package cbbd_pkg;

    localparam int BLOCK_DATA_BYTES_DEF     = 64;
    localparam int PREAMBLE_COUNT_WIDTH_DEF = 14;

    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;
    localparam int THRESH_W   = 14;

    localparam logic [1:0] REG_SHORT_LIMIT   = 2'd0;
    localparam logic [1:0] REG_START_PREAMBLE = 2'd1;
    localparam logic [1:0] REG_BLOCK_PREAMBLE = 2'd2;
    localparam logic [1:0] REG_NEW_RECORD     = 2'd3;

    localparam logic [7:0]          SHORT_LIMIT_RST    = 8'd24;
    localparam logic [THRESH_W-1:0] START_PREAMBLE_RST = 14'd3000;
    localparam logic [THRESH_W-1:0] BLOCK_PREAMBLE_RST = 14'd60;
    localparam logic [THRESH_W-1:0] NEW_RECORD_RST     = 14'd3072;

    localparam logic [7:0] MARK_BYTE = 8'hFF;

    localparam logic KIND_DATA   = 1'b0;
    localparam logic KIND_HEADER = 1'b1;

    typedef struct packed {
        logic [7:0]          short_limit;
        logic [THRESH_W-1:0] start_preamble;
        logic [THRESH_W-1:0] block_preamble;
        logic [THRESH_W-1:0] new_record;
    } cfg_t;

    typedef struct packed {
        logic accept;
        logic emitting;
        logic emit_load;
    } cmd_t;

    typedef struct packed {
        logic blk_done;
        logic out_full;
        logic emit_last;
    } sts_t;

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_READ = 3'b010,
        ST_LOAD = 3'b100
    } state_t;

endpackage

// File: rtl/core/cbbd_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cbbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 66
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: rtl/core/cbbd_ctrl.sv
// Controller: input acceptance and sequencing of the block byte emission.
module cbbd_ctrl
    import cbbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic pulse_valid,
    input  logic result_stall,
    input  sts_t sts,
    output logic pulse_stall,
    output cmd_t cmd
);

    state_t state_reg, state_next;
    logic   slot_free;

    assign slot_free = !sts.out_full || !result_stall;

    always_comb
    begin
        state_next    = state_reg;
        cmd.accept    = 1'b0;
        cmd.emit_load = 1'b0;
        cmd.emitting  = 1'b1;
        pulse_stall   = 1'b1;
        case (state_reg)
            ST_IDLE:
            begin
                cmd.emitting = 1'b0;
                pulse_stall  = !slot_free;
                cmd.accept   = pulse_valid && slot_free;
                if (cmd.accept && sts.blk_done)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_LOAD;
            end
            ST_LOAD:
            begin
                if (slot_free)
                begin
                    cmd.emit_load = 1'b1;
                    state_next    = sts.emit_last ? ST_IDLE : ST_READ;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/cbbd_dpath.sv
// Datapath: bit slicing, preamble hunt, byte framing, block checks and result register.
module cbbd_dpath
    import cbbd_pkg::*;
#(
    parameter int BLOCK_DATA_BYTES     = BLOCK_DATA_BYTES_DEF,
    parameter int PREAMBLE_COUNT_WIDTH = PREAMBLE_COUNT_WIDTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  cfg_t        cfg,
    input  cmd_t        cmd,
    input  logic [15:0] pulse_width,
    input  logic        result_stall,
    output sts_t        sts,
    output logic        result_valid,
    output logic        kind,
    output logic [7:0]  data_byte,
    output logic [5:0]  byte_index,
    output logic [7:0]  block_number,
    output logic [1:0]  checksum_status,
    output logic        copies_differ,
    output logic        misaligned,
    output logic        errors_found,
    output logic        errors_fixable,
    output logic [7:0]  record_count,
    output logic        last
);

    localparam int COPY_BYTES = BLOCK_DATA_BYTES + 2;
    localparam int IW = $clog2(COPY_BYTES);
    localparam int EW = $clog2(BLOCK_DATA_BYTES);
    localparam int PW = PREAMBLE_COUNT_WIDTH;
    localparam int CW = (PW > THRESH_W) ? PW : THRESH_W;
    localparam logic [IW-1:0] LAST_POS  = IW'(COPY_BYTES - 1);
    localparam logic [EW-1:0] LAST_EMIT = EW'(BLOCK_DATA_BYTES - 1);
    localparam logic [PW-1:0] PRE_MAX   = {PW{1'b1}};

    // Decoder state.
    logic          half_reg, half_next;
    logic [7:0]    shift_reg, shift_next;
    logic [2:0]    bitpos_reg, bitpos_next;
    logic [PW-1:0] pcount_reg, pcount_next;
    logic          hunt_reg, hunt_next;
    logic          useblk_reg, useblk_next;
    logic          hdrdone_reg, hdrdone_next;
    logic [1:0]    hbi_reg, hbi_next;
    logic [7:0]    hdr1_reg, hdr1_next;
    logic [IW-1:0] bbi_reg, bbi_next;
    logic          copy_reg, copy_next;
    logic [7:0]    blkcnt_reg, blkcnt_next;
    logic [7:0]    reccnt_reg, reccnt_next;
    logic          err_reg, err_next;
    logic          fix_reg, fix_next;
    logic [7:0]    sum_reg, sum_next;
    logic          bad0_reg, bad0_next;
    logic          misal0_reg, misal0_next;
    logic          differ_reg, differ_next;
    // Block check results held for the emission.
    logic [1:0]    stat_reg, stat_next;
    logic          edif_reg, edif_next;
    logic          emis_reg, emis_next;
    logic          usesec_reg, usesec_next;
    logic [EW-1:0] emit_reg;

    logic [7:0]    rdata0, rdata1;
    logic [IW-1:0] raddr;
    logic          we0, we1;
    logic          hdr_done, blk_done;
    logic          bit_val, have_bit, byte_done, bad1, misal_now, differ_now;
    logic [7:0]    byte_val;
    logic [CW-1:0] pc_ext;
    logic [CW-1:0] need_ext;

    // Output register.
    logic          ovalid_reg;
    logic          okind_reg;
    logic [7:0]    odata_reg;
    logic [5:0]    oidx_reg;
    logic [7:0]    oblk_reg;
    logic [1:0]    ostat_reg;
    logic          odif_reg, omis_reg, oerr_reg, ofix_reg, olast_reg;
    logic [7:0]    orec_reg;

    always_comb
    begin
        half_next    = half_reg;
        shift_next   = shift_reg;
        bitpos_next  = bitpos_reg;
        pcount_next  = pcount_reg;
        hunt_next    = hunt_reg;
        useblk_next  = useblk_reg;
        hdrdone_next = hdrdone_reg;
        hbi_next     = hbi_reg;
        hdr1_next    = hdr1_reg;
        bbi_next     = bbi_reg;
        copy_next    = copy_reg;
        reccnt_next  = reccnt_reg;
        err_next     = err_reg;
        fix_next     = fix_reg;
        sum_next     = sum_reg;
        bad0_next    = bad0_reg;
        misal0_next  = misal0_reg;
        differ_next  = differ_reg;
        stat_next    = stat_reg;
        edif_next    = edif_reg;
        emis_next    = emis_reg;
        usesec_next  = usesec_reg;
        hdr_done     = 1'b0;
        blk_done     = 1'b0;
        we0          = 1'b0;
        we1          = 1'b0;
        bit_val      = 1'b0;
        have_bit     = 1'b0;
        byte_done    = 1'b0;
        byte_val     = 8'd0;
        bad1         = 1'b0;
        misal_now    = 1'b0;
        differ_now   = 1'b0;
        pc_ext       = CW'(pcount_reg);
        need_ext     = useblk_reg ? CW'(cfg.block_preamble) : CW'(cfg.start_preamble);

        if (pulse_width < {8'd0, cfg.short_limit})
        begin
            half_next = !half_reg;
            have_bit  = half_reg;
            bit_val   = 1'b1;
        end
        else
        begin
            half_next = 1'b0;
            have_bit  = 1'b1;
        end

        if (have_bit)
        begin
            if (bit_val && hunt_reg)
            begin
                if (pc_ext > CW'(cfg.new_record))
                begin
                    reccnt_next = reccnt_reg + 8'd1;
                    if (hdrdone_reg)
                    begin
                        hdrdone_next = 1'b0;
                        hbi_next     = 2'd0;
                    end
                end
                if (pc_ext > need_ext)
                begin
                    hunt_next = 1'b0;
                end
                pcount_next = '0;
            end
            if (hunt_next)
            begin
                if (pcount_next != PRE_MAX)
                begin
                    pcount_next = pcount_next + PW'(1);
                end
            end
            else
            begin
                shift_next = {shift_reg[6:0], bit_val};
                if (bitpos_reg == 3'd7)
                begin
                    byte_done   = 1'b1;
                    byte_val    = shift_next;
                    shift_next  = 8'd0;
                    bitpos_next = 3'd0;
                end
                else
                begin
                    bitpos_next = bitpos_reg + 3'd1;
                end
            end
        end

        if (byte_done)
        begin
            if (!hdrdone_next)
            begin
                if (hbi_next == 2'd1)
                begin
                    hdr1_next = byte_val;
                end
                if (hbi_next == 2'd2)
                begin
                    hbi_next     = 2'd0;
                    hdrdone_next = 1'b1;
                    hunt_next    = 1'b1;
                    useblk_next  = 1'b1;
                    hdr_done     = 1'b1;
                end
                else
                begin
                    hbi_next = hbi_next + 2'd1;
                end
            end
            else
            begin
                we0 = !copy_reg;
                we1 = copy_reg;
                // Running sum of the data bytes of the copy being received.
                if (bbi_reg == '0)
                begin
                    sum_next = 8'd0;
                end
                else if (bbi_reg != LAST_POS)
                begin
                    sum_next = sum_reg + byte_val;
                end
                // Copy one is compared against copy zero at the same position.
                differ_now = ((bbi_reg == '0) ? 1'b0 : differ_reg) || (byte_val != rdata0);
                if (copy_reg)
                begin
                    differ_next = differ_now;
                end
                else if (bbi_reg == '0)
                begin
                    misal0_next = (byte_val != MARK_BYTE);
                end
                if (bbi_reg == LAST_POS)
                begin
                    bbi_next    = '0;
                    hunt_next   = 1'b1;
                    useblk_next = 1'b1;
                    copy_next   = !copy_reg;
                    if (!copy_reg)
                    begin
                        bad0_next = (sum_reg != byte_val);
                    end
                    else
                    begin
                        blk_done    = 1'b1;
                        bad1        = (sum_reg != byte_val);
                        misal_now   = misal0_reg;
                        stat_next   = {bad1, bad0_reg};
                        edif_next   = differ_now;
                        emis_next   = misal_now;
                        usesec_next = bad0_reg && !bad1;
                        if (misal_now || differ_now || bad0_reg || bad1)
                        begin
                            err_next = 1'b1;
                        end
                        if (misal_now || (bad0_reg && bad1))
                        begin
                            fix_next = 1'b0;
                        end
                    end
                end
                else
                begin
                    bbi_next = bbi_reg + IW'(1);
                end
            end
        end
    end

    assign raddr = cmd.emitting ? (IW'(emit_reg) + IW'(1)) : bbi_reg;
    assign blkcnt_next = (cmd.emit_load && emit_reg == LAST_EMIT) ? blkcnt_reg + 8'd1
                                                                   : blkcnt_reg;

    cbbd_ram #(.WIDTH(8), .DEPTH(COPY_BYTES)) u_copy0 (
        .clk   (clk),
        .we    (cmd.accept && we0),
        .waddr (bbi_reg),
        .wdata (byte_val),
        .raddr (raddr),
        .rdata (rdata0)
    );

    cbbd_ram #(.WIDTH(8), .DEPTH(COPY_BYTES)) u_copy1 (
        .clk   (clk),
        .we    (cmd.accept && we1),
        .waddr (bbi_reg),
        .wdata (byte_val),
        .raddr (raddr),
        .rdata (rdata1)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg    <= 1'b0;
            shift_reg   <= 8'd0;
            bitpos_reg  <= 3'd0;
            pcount_reg  <= '0;
            hunt_reg    <= 1'b1;
            useblk_reg  <= 1'b0;
            hdrdone_reg <= 1'b0;
            hbi_reg     <= 2'd0;
            bbi_reg     <= '0;
            copy_reg    <= 1'b0;
            blkcnt_reg  <= 8'd0;
            reccnt_reg  <= 8'd0;
            err_reg     <= 1'b0;
            fix_reg     <= 1'b1;
            emit_reg    <= '0;
            ovalid_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.accept)
            begin
                half_reg    <= half_next;
                shift_reg   <= shift_next;
                bitpos_reg  <= bitpos_next;
                pcount_reg  <= pcount_next;
                hunt_reg    <= hunt_next;
                useblk_reg  <= useblk_next;
                hdrdone_reg <= hdrdone_next;
                hbi_reg     <= hbi_next;
                bbi_reg     <= bbi_next;
                copy_reg    <= copy_next;
                reccnt_reg  <= reccnt_next;
                err_reg     <= err_next;
                fix_reg     <= fix_next;
            end
            blkcnt_reg <= blkcnt_next;
            if (cmd.emit_load)
            begin
                emit_reg <= (emit_reg == LAST_EMIT) ? '0 : emit_reg + EW'(1);
            end
            if ((cmd.accept && hdr_done) || cmd.emit_load)
            begin
                ovalid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                ovalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hdr1_reg   <= hdr1_next;
            sum_reg    <= sum_next;
            bad0_reg   <= bad0_next;
            misal0_reg <= misal0_next;
            differ_reg <= differ_next;
            stat_reg   <= stat_next;
            edif_reg   <= edif_next;
            emis_reg   <= emis_next;
            usesec_reg <= usesec_next;
        end
        if (cmd.accept && hdr_done)
        begin
            okind_reg <= KIND_HEADER;
            odata_reg <= hdr1_next;
            oidx_reg  <= 6'd0;
            oblk_reg  <= blkcnt_reg;
            ostat_reg <= 2'd0;
            odif_reg  <= 1'b0;
            omis_reg  <= 1'b0;
            oerr_reg  <= err_next;
            ofix_reg  <= fix_next;
            orec_reg  <= reccnt_next;
            olast_reg <= 1'b1;
        end
        else if (cmd.emit_load)
        begin
            okind_reg <= KIND_DATA;
            odata_reg <= usesec_reg ? rdata1 : rdata0;
            oidx_reg  <= 6'(emit_reg);
            oblk_reg  <= blkcnt_reg;
            ostat_reg <= stat_reg;
            odif_reg  <= edif_reg;
            omis_reg  <= emis_reg;
            oerr_reg  <= err_reg;
            ofix_reg  <= fix_reg;
            orec_reg  <= reccnt_reg;
            olast_reg <= (emit_reg == LAST_EMIT);
        end
    end

    assign sts.blk_done  = blk_done;
    assign sts.out_full  = ovalid_reg;
    assign sts.emit_last = (emit_reg == LAST_EMIT);

    assign result_valid    = ovalid_reg;
    assign kind            = okind_reg;
    assign data_byte       = odata_reg;
    assign byte_index      = oidx_reg;
    assign block_number    = oblk_reg;
    assign checksum_status = ostat_reg;
    assign copies_differ   = odif_reg;
    assign misaligned      = omis_reg;
    assign errors_found    = oerr_reg;
    assign errors_fixable  = ofix_reg;
    assign record_count    = orec_reg;
    assign last            = olast_reg;

endmodule

// File: rtl/core/cassette_bit_block_deframer.sv
// A header result is registered in the cycle after its final pulse is taken.
// A completed second block copy leads to BLOCK_DATA_BYTES results, each via the READ
// and LOAD states, paced by the registered read of the copy RAMs; no pulse is taken
// during that emission. Throughput otherwise is one pulse per cycle while the result
// register is free or not stalled. Reset (rst_n, asynchronous, active low) restores
// configuration defaults and decoder control state; the copy RAMs are not cleared.
module cassette_bit_block_deframer
    import cbbd_pkg::*;
#(
    parameter int BLOCK_DATA_BYTES     = BLOCK_DATA_BYTES_DEF,
    parameter int PREAMBLE_COUNT_WIDTH = PREAMBLE_COUNT_WIDTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  pulse_valid,
    output logic                  pulse_stall,
    input  logic [15:0]           pulse_width,
    output logic                  result_valid,
    input  logic                  result_stall,
    output logic                  kind,
    output logic [7:0]            data_byte,
    output logic [5:0]            byte_index,
    output logic [7:0]            block_number,
    output logic [1:0]            checksum_status,
    output logic                  copies_differ,
    output logic                  misaligned,
    output logic                  errors_found,
    output logic                  errors_fixable,
    output logic [7:0]            record_count,
    output logic                  last
);

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic cfg_we;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.short_limit    <= SHORT_LIMIT_RST;
            cfg_reg.start_preamble <= START_PREAMBLE_RST;
            cfg_reg.block_preamble <= BLOCK_PREAMBLE_RST;
            cfg_reg.new_record     <= NEW_RECORD_RST;
        end
        else if (cfg_we)
        begin
            case (paddr[3:2])
                REG_SHORT_LIMIT:    cfg_reg.short_limit    <= pwdata[7:0];
                REG_START_PREAMBLE: cfg_reg.start_preamble <= pwdata[THRESH_W-1:0];
                REG_BLOCK_PREAMBLE: cfg_reg.block_preamble <= pwdata[THRESH_W-1:0];
                REG_NEW_RECORD:     cfg_reg.new_record     <= pwdata[THRESH_W-1:0];
                default:            cfg_reg.short_limit    <= cfg_reg.short_limit;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_SHORT_LIMIT:    prdata = {24'd0, cfg_reg.short_limit};
            REG_START_PREAMBLE: prdata = {18'd0, cfg_reg.start_preamble};
            REG_BLOCK_PREAMBLE: prdata = {18'd0, cfg_reg.block_preamble};
            REG_NEW_RECORD:     prdata = {18'd0, cfg_reg.new_record};
            default:            prdata = '0;
        endcase
    end

    cbbd_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .pulse_valid  (pulse_valid),
        .result_stall (result_stall),
        .sts          (sts),
        .pulse_stall  (pulse_stall),
        .cmd          (cmd)
    );

    cbbd_dpath #(
        .BLOCK_DATA_BYTES     (BLOCK_DATA_BYTES),
        .PREAMBLE_COUNT_WIDTH (PREAMBLE_COUNT_WIDTH)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .cmd             (cmd),
        .pulse_width     (pulse_width),
        .result_stall    (result_stall),
        .sts             (sts),
        .result_valid    (result_valid),
        .kind            (kind),
        .data_byte       (data_byte),
        .byte_index      (byte_index),
        .block_number    (block_number),
        .checksum_status (checksum_status),
        .copies_differ   (copies_differ),
        .misaligned      (misaligned),
        .errors_found    (errors_found),
        .errors_fixable  (errors_fixable),
        .record_count    (record_count),
        .last            (last)
    );

`ifndef ASSERT_OFF
    // A request is never taken while a stalled result still occupies the output register.
    a_no_take_on_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(pulse_valid && !pulse_stall && result_valid && result_stall))
        else $error("pulse taken while result register blocked");

    // Pulses are held off for the whole emission of a block.
    a_hold_in_emit: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emitting |-> pulse_stall)
        else $error("pulse input open during block emission");

    // Header results always close their run.
    a_header_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_HEADER) |-> (last && byte_index == 6'd0))
        else $error("header result malformed");

    // The final data byte of a block sits at the last block position.
    a_block_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && kind == KIND_DATA && last)
            |-> (byte_index == 6'(BLOCK_DATA_BYTES - 1)))
        else $error("block run ended at wrong position");
`endif

endmodule
